// File: src/irct_pkg.sv
package irct_pkg;

    localparam int OP_BITS     = 2;
    localparam int ID_BITS     = 16;
    localparam int VALUE_BITS  = 20;
    localparam int STATUS_BITS = 3;

    localparam logic [OP_BITS-1:0] OP_INC = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SET = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DEC = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_SAT       = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_UNDER     = 3'd4;

endpackage

// File: src/irct_if.sv
interface irct_req_if;
    logic                            valid;
    logic                            ready;
    logic [irct_pkg::OP_BITS-1:0]    op;
    logic [irct_pkg::ID_BITS-1:0]    image_id;
    logic [irct_pkg::VALUE_BITS-1:0] set_value;

    modport source (output valid, op, image_id, set_value, input ready);
    modport sink (input valid, op, image_id, set_value, output ready);
endinterface

interface irct_res_if;
    logic                             valid;
    logic                             ready;
    logic [irct_pkg::VALUE_BITS-1:0]  count_after;
    logic                             release_valid;
    logic [irct_pkg::ID_BITS-1:0]     release_id;
    logic [irct_pkg::STATUS_BITS-1:0] status;

    modport source (output valid, count_after, release_valid, release_id, status, input ready);
    modport sink (input valid, count_after, release_valid, release_id, status, output ready);
endinterface

// File: src/irct_ram.sv
module irct_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/irct_queue.sv
module irct_queue #(
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  not_empty
);

    localparam int DEPTH = 2;

    item_t      entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign do_push   = push && (fill_reg != 2'(DEPTH));
    assign do_pop    = pop && (fill_reg != 2'd0);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/irct_front.sv
module irct_front #(
    parameter int  ENTRIES    = 16,
    parameter int  COUNT_BITS = 20,
    parameter type cmd_t      = logic,
    parameter type upd_t      = logic
) (
    input  logic            clk,
    input  logic            rst_n,
    irct_req_if.sink        request,
    input  logic            settled,
    input  upd_t            upd,
    output logic            cmd_push,
    output cmd_t            cmd
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [32:0] CMAX_W = (33'd1 << COUNT_BITS) - 33'd1;

    logic                            hold_valid_reg;
    logic                            hold_valid_next;
    logic [irct_pkg::OP_BITS-1:0]    op_reg;
    logic [irct_pkg::ID_BITS-1:0]    id_reg;
    logic [irct_pkg::VALUE_BITS-1:0] value_reg;

    logic [ENTRIES-1:0]              slot_valid_reg;
    logic [irct_pkg::ID_BITS-1:0]    slot_id_reg [ENTRIES];

    logic [ENTRIES-1:0]              match_vec;
    logic [ENTRIES-1:0]              free_vec;
    logic [ENTRIES-1:0]              free_first;
    logic [IW-1:0]                   hit_idx;
    logic [IW-1:0]                   free_idx;
    logic [32:0]                     value_w;
    logic                            value_sat;
    logic                            accept;

    assign accept        = request.valid && request.ready;
    assign cmd_push      = hold_valid_reg && settled;
    assign request.ready = !hold_valid_reg || cmd_push;

    // associative search over the slots
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = slot_valid_reg[i] && (slot_id_reg[i] == id_reg);
        end
    end

    assign free_vec   = ~slot_valid_reg;
    assign free_first = free_vec & (~free_vec + ENTRIES'(1));

    // ids are unique among valid slots, so the match is one-hot
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
            if (free_first[i])
            begin
                free_idx = free_idx | IW'(i);
            end
        end
    end

    assign value_w   = 33'(value_reg);
    assign value_sat = (op_reg == irct_pkg::OP_SET) && (value_w > CMAX_W);

    always_comb
    begin
        cmd.op       = op_reg;
        cmd.image_id = id_reg;
        cmd.sat      = value_sat;
        if (op_reg == irct_pkg::OP_INC)
        begin
            cmd.new_count = COUNT_BITS'(1);
        end
        else if (value_sat)
        begin
            cmd.new_count = CMAX_W[COUNT_BITS-1:0];
        end
        else
        begin
            cmd.new_count = value_w[COUNT_BITS-1:0];
        end
        cmd.hit      = |match_vec;
        cmd.hit_idx  = hit_idx;
        cmd.has_free = |free_vec;
        cmd.free_idx = free_idx;
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (upd.set_valid)
            begin
                slot_valid_reg[upd.idx] <= 1'b1;
            end
            else if (upd.clear_valid)
            begin
                slot_valid_reg[upd.idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= request.op;
            id_reg    <= request.image_id;
            value_reg <= request.set_value;
        end
        if (upd.set_valid)
        begin
            slot_id_reg[upd.idx] <= upd.image_id;
        end
    end

endmodule

// File: src/irct_back.sv
module irct_back #(
    parameter int  ENTRIES    = 16,
    parameter int  COUNT_BITS = 20,
    parameter type cmd_t      = logic,
    parameter type upd_t      = logic
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cmd_t            head,
    input  logic            head_valid,
    output logic            pop,
    output logic            idle,
    output upd_t            upd,
    irct_res_if.source      result
);

    localparam int IW = $clog2(ENTRIES);
    localparam int VB = irct_pkg::VALUE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    cmd_t                               cmd_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [VB-1:0]                      count_after_reg;
    logic                               release_valid_reg;
    logic [irct_pkg::ID_BITS-1:0]       release_id_reg;
    logic [irct_pkg::STATUS_BITS-1:0]   status_reg;

    logic [COUNT_BITS-1:0]              cur;
    logic                               wr_en;
    logic [IW-1:0]                      wr_addr;
    logic [COUNT_BITS-1:0]              wr_data;
    logic [COUNT_BITS-1:0]              cnt;
    logic [COUNT_BITS+VB-1:0]           cnt_ext;
    logic [irct_pkg::STATUS_BITS-1:0]   status;
    logic                               rel;
    logic                               exec;

    assign exec = (state_reg == S_EXEC);
    assign idle = (state_reg == S_IDLE);
    assign pop  = idle && head_valid && !out_valid_reg;

    irct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (pop),
        .rd_addr (head.hit_idx),
        .rd_data (cur)
    );

    // read-modify-write of one slot
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = cmd_reg.hit ? cmd_reg.hit_idx : cmd_reg.free_idx;
        wr_data         = cur;
        cnt             = '0;
        status          = irct_pkg::STATUS_OK;
        rel             = 1'b0;
        upd.set_valid   = 1'b0;
        upd.clear_valid = 1'b0;
        upd.idx         = wr_addr;
        upd.image_id    = cmd_reg.image_id;
        case (cmd_reg.op)
            irct_pkg::OP_INC, irct_pkg::OP_SET:
            begin
                if (cmd_reg.hit)
                begin
                    if (cmd_reg.op == irct_pkg::OP_INC)
                    begin
                        if (cur == COUNT_MAX)
                        begin
                            cnt    = COUNT_MAX;
                            status = irct_pkg::STATUS_SAT;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = cur + COUNT_ONE;
                            cnt     = cur + COUNT_ONE;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = cmd_reg.new_count;
                        cnt     = cmd_reg.new_count;
                        status  = cmd_reg.sat ? irct_pkg::STATUS_SAT : irct_pkg::STATUS_OK;
                    end
                end
                else if (cmd_reg.has_free)
                begin
                    wr_en         = 1'b1;
                    wr_data       = cmd_reg.new_count;
                    cnt           = cmd_reg.new_count;
                    upd.set_valid = 1'b1;
                    status        = cmd_reg.sat ? irct_pkg::STATUS_SAT : irct_pkg::STATUS_OK;
                end
                else
                begin
                    status = irct_pkg::STATUS_FULL;
                end
            end
            irct_pkg::OP_DEC:
            begin
                if (!cmd_reg.hit)
                begin
                    status = irct_pkg::STATUS_NOT_FOUND;
                end
                else if (cur == '0)
                begin
                    status = irct_pkg::STATUS_UNDER;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = cur - COUNT_ONE;
                    cnt     = cur - COUNT_ONE;
                    if (cur == COUNT_ONE)
                    begin
                        rel             = 1'b1;
                        upd.clear_valid = 1'b1;
                    end
                end
            end
            default:
            begin
                cnt = cmd_reg.hit ? cur : '0;
            end
        endcase
        if (!exec)
        begin
            wr_en           = 1'b0;
            upd.set_valid   = 1'b0;
            upd.clear_valid = 1'b0;
        end
    end

    assign cnt_ext = (COUNT_BITS + VB)'(cnt);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (exec)
        begin
            count_after_reg   <= cnt_ext[VB-1:0];
            release_valid_reg <= rel;
            release_id_reg    <= rel ? cmd_reg.image_id : '0;
            status_reg        <= status;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.count_after   = count_after_reg;
    assign result.release_valid = release_valid_reg;
    assign result.release_id    = release_id_reg;
    assign result.status        = status_reg;

endmodule

// File: src/image_reference_count_table.sv
// Reference count table keyed by 16-bit image id, ENTRIES slots wide. An item
// (increase, set or decrease) is searched against all valid slot ids at once in
// the front, queued, then the back reads the slot's count from a RAM and writes
// it back, and the result waits in an output register. The next item's search
// waits for the count RAM write-back because it depends on the slots it leaves.
// A new item is accepted while a result waits; a waiting result holds the back.
// Slot counts need no clearing after reset: only the counts of valid slots are
// ever used.
module image_reference_count_table #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    irct_req_if.sink    request,
    irct_res_if.source  result
);

    localparam int IW = $clog2(ENTRIES);

    typedef struct packed {
        logic [irct_pkg::OP_BITS-1:0] op;
        logic [irct_pkg::ID_BITS-1:0] image_id;
        logic [COUNT_BITS-1:0]        new_count;
        logic                         sat;
        logic                         hit;
        logic [IW-1:0]                hit_idx;
        logic                         has_free;
        logic [IW-1:0]                free_idx;
    } cmd_t;

    typedef struct packed {
        logic                         set_valid;
        logic                         clear_valid;
        logic [IW-1:0]                idx;
        logic [irct_pkg::ID_BITS-1:0] image_id;
    } upd_t;

    cmd_t front_cmd;
    cmd_t queue_head;
    upd_t slot_upd;
    logic cmd_push;
    logic cmd_pop;
    logic queue_not_empty;
    logic back_idle;
    logic settled;

    assign settled = back_idle && !queue_not_empty;

    irct_front #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .cmd_t      (cmd_t),
        .upd_t      (upd_t)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .settled  (settled),
        .upd      (slot_upd),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    irct_queue #(
        .item_t (cmd_t)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_item (front_cmd),
        .pop       (cmd_pop),
        .head      (queue_head),
        .not_empty (queue_not_empty)
    );

    irct_back #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .cmd_t      (cmd_t),
        .upd_t      (upd_t)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (queue_head),
        .head_valid (queue_not_empty),
        .pop        (cmd_pop),
        .idle       (back_idle),
        .upd        (slot_upd),
        .result     (result)
    );

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irct_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 20;
    localparam int IDLE_LIMIT = 1000;
    localparam int POOL_SIZE  = 24;
    localparam int RANDOM_ITEMS = 875;

    // op code the block leaves unused: reports the current count only
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  count_after;
        logic                   release_valid;
        logic [ID_BITS-1:0]     release_id;
        logic [STATUS_BITS-1:0] status;
    } outcome_t;

    class refcount_tracker;
        bit                    slot_used [ENTRIES];
        logic [ID_BITS-1:0]    slot_tag  [ENTRIES];
        logic [COUNT_BITS-1:0] slot_refs [ENTRIES];
        outcome_t              expected_results [$];
        int                    mismatches = 0;

        function void note_request(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id,
                                   logic [VALUE_BITS-1:0] value);
            outcome_t              o;
            int                    hit;
            int                    spare;
            logic [COUNT_BITS-1:0] fresh;
            hit   = -1;
            spare = -1;
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (slot_used[i] && slot_tag[i] == id)
                    hit = i;
                if (!slot_used[i])
                    spare = i;
            end
            o        = '0;
            o.status = STATUS_OK;
            case (op)
                OP_INC, OP_SET:
                begin
                    fresh = COUNT_BITS'(1);
                    if (op == OP_SET)
                    begin
                        if (value > COUNT_MAX)
                        begin
                            fresh    = COUNT_MAX;
                            o.status = STATUS_SAT;
                        end
                        else
                            fresh = COUNT_BITS'(value);
                    end
                    if (hit >= 0)
                    begin
                        if (op == OP_SET)
                            slot_refs[hit] = fresh;
                        else if (slot_refs[hit] == COUNT_MAX)
                            o.status = STATUS_SAT;
                        else
                            slot_refs[hit] = slot_refs[hit] + 1'b1;
                        o.count_after = VALUE_BITS'(slot_refs[hit]);
                    end
                    else if (spare >= 0)
                    begin
                        slot_used[spare] = 1'b1;
                        slot_tag[spare]  = id;
                        slot_refs[spare] = fresh;
                        o.count_after    = VALUE_BITS'(fresh);
                    end
                    else
                        o.status = STATUS_FULL;
                end
                OP_DEC:
                begin
                    if (hit < 0)
                        o.status = STATUS_NOT_FOUND;
                    else if (slot_refs[hit] == 0)
                        o.status = STATUS_UNDER;
                    else
                    begin
                        slot_refs[hit] = slot_refs[hit] - 1'b1;
                        o.count_after  = VALUE_BITS'(slot_refs[hit]);
                        if (slot_refs[hit] == 0)
                        begin
                            slot_used[hit]  = 1'b0;
                            o.release_valid = 1'b1;
                            o.release_id    = slot_tag[hit];
                        end
                    end
                end
                default:
                begin
                    if (hit >= 0)
                        o.count_after = VALUE_BITS'(slot_refs[hit]);
                end
            endcase
            expected_results.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: count_after %0d status %0d",
                       got.count_after, got.status);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.count_after !== want.count_after)
            begin
                $error("count_after: expected %0d, actual %0d", want.count_after,
                       got.count_after);
                mismatches++;
            end
            if (got.release_valid !== want.release_valid)
            begin
                $error("release_valid: expected %0d, actual %0d", want.release_valid,
                       got.release_valid);
                mismatches++;
            end
            if (got.release_id !== want.release_id)
            begin
                $error("release_id: expected %h, actual %h", want.release_id,
                       got.release_id);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   quiet_cycles = 0;

    logic [ID_BITS-1:0] id_pool [POOL_SIZE];

    refcount_tracker tracker = new();

    irct_req_if req_bus();
    irct_res_if res_bus();

    image_reference_count_table #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (res_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= IDLE_LIMIT)
                begin
                    $display("image_reference_count_table: mismatch");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id,
                                logic [VALUE_BITS-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.op        <= op;
        req_bus.image_id  <= id;
        req_bus.set_value <= value;
        do
            @(posedge clk);
        while (!req_bus.ready);
        tracker.note_request(op, id, value);
    endtask

    task automatic send_random_request();
        int                    pick;
        logic [OP_BITS-1:0]    op;
        logic [ID_BITS-1:0]    id;
        logic [VALUE_BITS-1:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            op = OP_INC;
        else if (pick < 52)
            op = OP_SET;
        else if (pick < 94)
            op = OP_DEC;
        else
            op = OP_QUERY;
        if ($urandom_range(0, 99) < 6)
            id = ID_BITS'($urandom_range(0, 65535));
        else
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 60)
            value = VALUE_BITS'($urandom_range(0, 3));
        else if (pick < 75)
            value = VALUE_MAX;
        else if (pick < 80)
            value = VALUE_MAX - 1'b1;
        else
            value = VALUE_BITS'($urandom);
        send_request(op, id, value);
    endtask

    initial
    begin
        outcome_t got;
        int       stall;
        res_bus.ready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_bus.valid);
            got.count_after   = res_bus.count_after;
            got.release_valid = res_bus.release_valid;
            got.release_id    = res_bus.release_id;
            got.status        = res_bus.status;
            tracker.check_result(got);
        end
    end

    initial
    begin
        req_bus.valid     = 1'b0;
        req_bus.op        = OP_INC;
        req_bus.image_id  = '0;
        req_bus.set_value = '0;
        steady            = 1'b0;
        rst_n             = 1'b0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_BITS'($urandom_range(0, 65535));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // saturation, set to zero, underflow, absent id, query, release
        send_request(OP_SET, 16'hFFFF, VALUE_MAX);
        send_request(OP_INC, 16'hFFFF, '0);
        send_request(OP_SET, 16'h0000, '0);
        send_request(OP_DEC, 16'h0000, VALUE_MAX);
        send_request(OP_DEC, 16'h5555, '0);
        send_request(OP_QUERY, 16'hFFFF, '0);
        send_request(OP_INC, 16'h0000, '0);
        send_request(OP_DEC, 16'h0000, '0);
        // fill every slot, then try to add two more ids
        for (int i = 0; i < ENTRIES - 1; i++)
            send_request(i[0] ? OP_SET : OP_INC, ID_BITS'(16'h1000 + i),
                         VALUE_BITS'(i % 4));
        send_request(OP_INC, 16'h2222, '0);
        send_request(OP_SET, 16'h3333, 20'h00005);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n % 50 == 49)
                id_pool[$urandom_range(2, POOL_SIZE - 1)] =
                    ID_BITS'($urandom_range(0, 65535));
            send_random_request();
        end
        req_bus.valid <= 1'b0;

        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
            $display("image_reference_count_table: match");
        else
            $display("image_reference_count_table: mismatch");
        $finish;
    end
endmodule

// File: filelist.f
src/irct_pkg.sv
src/irct_if.sv
src/irct_ram.sv
src/irct_queue.sv
src/irct_front.sv
src/irct_back.sv
src/image_reference_count_table.sv
tb/tb.sv
